// File: hw/rtl/pss_pkg.sv
`default_nettype none

package pss_pkg;

	// Table capacity and derived widths
	localparam int MAX_ITEMS = 64;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int POS_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	// Priority search is split into groups of eight cells
	localparam int GRP_SZ = 8;
	localparam int GRP_W  = $clog2(GRP_SZ);
	localparam int NGRP   = (MAX_ITEMS + GRP_SZ - 1) / GRP_SZ;
	localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

	// Payload widths
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 7;
	localparam int STAT_W = 2;

	localparam logic [IDX_W-1:0] NONE_IDX = '1;

	typedef enum logic [STAT_W-1:0] {
		STAT_FOUND = 2'd0,
		STAT_NONE  = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_GRP,
		S_FIN
	} state_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic                    shift;
		logic signed [VAL_W:0]   diff;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/pss_in_if.sv
`default_nettype none

interface pss_in_if;
	import pss_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    last;

	modport source (output valid, value, last, input ready);
	modport sink   (input valid, value, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pss_out_if.sv
`default_nettype none

interface pss_out_if;
	import pss_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [IDX_W-1:0] first_index;
	logic signed [IDX_W-1:0] second_index;

	modport source (output valid, status, first_index, second_index, input ready);
	modport sink   (input valid, status, first_index, second_index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pss_cell.sv
`default_nettype none

// One table entry: holds a stored value, passes it to the next cell on a
// shift, and compares it against the broadcast difference every cycle.
module pss_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  pss_pkg::cell_ctl_t      ctl,
	input  wire  [pss_pkg::VAL_W-1:0]     din,
	output logic [pss_pkg::VAL_W-1:0]     dout,
	output logic                          hit
);
	import pss_pkg::*;

	logic [VAL_W-1:0] val_q;
	logic             hit_s1;

	// stored value, shifted in from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= din;
		end
	end

	// stored + value == target  <=>  stored == target - value (33 bits)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= ($signed({val_q[VAL_W-1], val_q}) == ctl.diff);
		end
	end

	assign dout = val_q;
	assign hit  = hit_s1;

endmodule

`default_nettype wire

// File: hw/rtl/pss_prio.sv
`default_nettype none

// Finds the lowest-numbered cell with a valid hit (the most recent entry).
// First level per group of eight is registered, second level is combinational.
module pss_prio (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [pss_pkg::MAX_ITEMS-1:0]     hit,
	input  wire  [pss_pkg::MAX_ITEMS-1:0]     mask,
	output logic                              found,
	output logic [pss_pkg::POS_W-1:0]         pos
);
	import pss_pkg::*;

	logic [NGRP*GRP_SZ-1:0] vec;
	logic [GRP_W-1:0]       loc_d    [NGRP];
	logic [NGRP-1:0]        grp_any_s2;
	logic [GRP_W-1:0]       grp_loc_s2 [NGRP];
	logic [NGRP_W-1:0]      gsel;

	assign vec = (NGRP*GRP_SZ)'(hit & mask);

	// lowest set bit inside each group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			loc_d[g] = '0;
			for (int b = GRP_SZ - 1; b >= 0; b--) begin
				if (vec[g*GRP_SZ + b]) begin
					loc_d[g] = GRP_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_any_s2 <= '0;
		end else begin
			for (int g = 0; g < NGRP; g++) begin
				grp_any_s2[g] <= |vec[g*GRP_SZ +: GRP_SZ];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_loc_s2[g] <= loc_d[g];
		end
	end

	// lowest group with a hit
	always_comb begin
		found = 1'b0;
		gsel  = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_s2[g]) begin
				found = 1'b1;
				gsel  = NGRP_W'(g);
			end
		end
	end

	assign pos = POS_W'({gsel, grp_loc_s2[gsel]});

endmodule

`default_nettype wire

// File: hw/rtl/pair_sum_stream_search.sv
`default_nettype none

// Streaming two-sum search. Array elements arrive on item, one per transfer,
// with last marking the end of the array. Each element is checked against
// the elements stored earlier in the same array; the first time one of them
// sums with it to target_sum (exact, no overflow), a result with the stored
// element's index and the current index goes out on result, the most recent
// stored match winning. Later elements of that array give nothing. An array
// that ends without a pair gives status 1, or 2 if more than MAX_ITEMS (64)
// elements arrived; elements past the capacity are neither stored nor
// searched. State clears at the end of each array; there is no clearing pass
// after reset. Each element passes through capture, compare in all table
// cells at once, group priority encode, then the decision, which waits while
// the result register is still full; item takes no new element until that
// decision is taken. target_sum is written through
// target_sum_we/target_sum_wdata; the user must write it only while idle, as
// the block itself does not enforce this.
module pair_sum_stream_search (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  target_sum_we,
	input  wire  signed [pss_pkg::VAL_W-1:0]     target_sum_wdata,
	pss_in_if.sink                               item,
	pss_out_if.source                            result
);
	import pss_pkg::*;

	state_t                  state_q, state_d;
	logic signed [VAL_W-1:0] target_q;
	logic [VAL_W-1:0]        value_s1;
	logic                    last_s1;
	logic signed [VAL_W:0]   diff_s1;
	logic [CNT_W-1:0]        count_q;
	logic                    done_q;
	logic                    cap_q;

	logic                    out_valid_q;
	logic [STAT_W-1:0]       out_status_q;
	logic [IDX_W-1:0]        out_first_q;
	logic [IDX_W-1:0]        out_second_q;

	logic                    in_xfer;
	logic                    fin_go;
	logic                    full;
	logic                    emit;
	status_t                 emit_status;
	logic [IDX_W-1:0]        emit_first;
	logic [IDX_W-1:0]        emit_second;
	logic                    do_shift;
	logic                    do_clear;
	logic                    set_done;
	logic                    set_cap;

	cell_ctl_t               ctl;
	logic [VAL_W-1:0]        chain [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]    hit_vec;
	logic [MAX_ITEMS-1:0]    mask;
	logic                    found;
	logic [POS_W-1:0]        pos;
	logic [CNT_W-1:0]        match_idx;

	assign in_xfer = item.valid && item.ready;
	assign full    = (count_q == CNT_W'(MAX_ITEMS));

	// target register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_sum_we) begin
			target_q <= target_sum_wdata;
		end
	end

	// capture stage
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_s1 <= item.value;
			last_s1  <= item.last;
			diff_s1  <= {target_q[VAL_W-1], target_q} - {item.value[VAL_W-1], item.value};
		end
	end

	// table cells: cell 0 holds the newest entry
	assign ctl.shift = do_shift;
	assign ctl.diff  = diff_s1;

	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		if (k == 0) begin : g_head
			pss_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.din    (value_s1),
				.dout   (chain[k]),
				.hit    (hit_vec[k])
			);
		end else begin : g_body
			pss_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.din    (chain[k-1]),
				.dout   (chain[k]),
				.hit    (hit_vec[k])
			);
		end
		// only cells written in this array take part
		assign mask[k] = (CNT_W'(k) < count_q);
	end

	pss_prio u_prio (
		.clk    (clk),
		.arst_n (arst_n),
		.hit    (hit_vec),
		.mask   (mask),
		.found  (found),
		.pos    (pos)
	);

	// cell k holds array index count-1-k
	assign match_idx = count_q - CNT_W'(1) - CNT_W'(pos);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) state_d = S_CMP;
			end
			S_CMP: state_d = S_GRP;
			S_GRP: state_d = S_FIN;
			S_FIN: begin
				if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// outputs and decision
	always_comb begin
		item.ready  = (state_q == S_IDLE);
		fin_go      = (state_q == S_FIN) && (!out_valid_q || result.ready);
		emit        = 1'b0;
		emit_status = STAT_NONE;
		emit_first  = NONE_IDX;
		emit_second = NONE_IDX;
		do_shift    = 1'b0;
		do_clear    = 1'b0;
		set_done    = 1'b0;
		set_cap     = 1'b0;
		if (fin_go) begin
			if (done_q) begin
				do_clear = last_s1;
			end else if (!full && found) begin
				emit        = 1'b1;
				emit_status = STAT_FOUND;
				emit_first  = IDX_W'(match_idx);
				emit_second = IDX_W'(count_q);
				do_clear    = last_s1;
				set_done    = !last_s1;
			end else begin
				do_shift = !full;
				set_cap  = full;
				if (last_s1) begin
					emit        = 1'b1;
					emit_status = (cap_q || full) ? STAT_FULL : STAT_NONE;
					do_clear    = 1'b1;
				end
			end
		end
	end

	// per-array state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			cap_q   <= 1'b0;
		end else if (do_clear) begin
			count_q <= '0;
			done_q  <= 1'b0;
			cap_q   <= 1'b0;
		end else begin
			if (do_shift) count_q <= count_q + CNT_W'(1);
			if (set_done) done_q <= 1'b1;
			if (set_cap) cap_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= emit_status;
			out_first_q  <= emit_first;
			out_second_q <= emit_second;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.first_index  = out_first_q;
	assign result.second_index = out_second_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("item count past capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		cap_q |-> full)
		else $error("capacity flag set with table not full");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && done_q) |-> (!emit && !do_shift))
		else $error("activity after a pair was reported");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !result.ready) |=> (state_q == S_FIN))
		else $error("decision taken while result register full");

	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_status == STAT_FOUND) |-> (found && !full))
		else $error("pair reported without a valid hit");

endmodule

`default_nettype wire
